// ===== design/bdy_pkg.sv =====
package bdy_pkg;

    // Field widths of the command and result transactions
    localparam int SIZE_W    = 17;
    localparam int OFFS_W    = 16;
    localparam int STAT_W    = 3;
    localparam int ORD_W     = 5;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    // Command codes
    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_ORDER   = 1'b0,
        REG_TOTAL_ORDER = 1'b1
    } reg_idx_t;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_BAD_SIZE  = 3'd1,
        STAT_NO_SPACE  = 3'd2,
        STAT_UNKNOWN   = 3'd3,
        STAT_FULL      = 3'd4
    } status_t;

    // One block table entry: order of the block and its free mark
    typedef struct packed {
        logic [ORD_W-1:0] order;
        logic             free;
    } entry_t;

    // Configuration seen by the sequencer
    typedef struct packed {
        logic [CFG_W-1:0] min_order;
        logic [CFG_W-1:0] total_order;
        logic             init;
        logic [ORD_W-1:0] init_order;
    } cfg_t;

    // Sequencer states
    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_WANT,
        S_ASCAN_RD,
        S_ASCAN_EV,
        S_ADECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SPLIT_WR,
        S_FSCAN_RD,
        S_FSCAN_EV,
        S_FHIT,
        S_MCHK,
        S_MEV,
        S_MWR,
        S_CRD,
        S_CWR,
        S_DONE
    } state_t;

endpackage

// ===== design/bdy_cmd_if.sv =====
interface bdy_cmd_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [bdy_pkg::SIZE_W-1:0]   request_size;
    logic [bdy_pkg::OFFS_W-1:0]   free_offset;

    modport source (output valid, output command, output request_size,
                    output free_offset, input ready);
    modport sink   (input valid, input command, input request_size,
                    input free_offset, output ready);
endinterface

// ===== design/bdy_rsp_if.sv =====
interface bdy_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bdy_pkg::STAT_W-1:0]   status;
    logic [bdy_pkg::OFFS_W-1:0]   block_offset;

    modport source (output valid, output status, output block_offset, input ready);
    modport sink   (input valid, input status, input block_offset, output ready);
endinterface

// ===== design/bdy_table.sv =====
module bdy_table #(
    parameter int MAX_BLOCKS = 256
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [$clog2(MAX_BLOCKS)-1:0]         waddr,
    input  bdy_pkg::entry_t                       wdata,
    input  logic [$clog2(MAX_BLOCKS)-1:0]         raddr,
    output bdy_pkg::entry_t                       rdata
);

    bdy_pkg::entry_t mem [MAX_BLOCKS];
    bdy_pkg::entry_t rdata_reg;

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bdy_ctrl.sv =====
module bdy_ctrl #(
    parameter int MAX_ORDER  = 16,
    parameter int MAX_BLOCKS = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bdy_pkg::cfg_t                         cfg,
    bdy_cmd_if.sink                               cmd,
    bdy_rsp_if.source                             rsp,
    output logic                                  mem_we,
    output logic [$clog2(MAX_BLOCKS)-1:0]         mem_waddr,
    output bdy_pkg::entry_t                       mem_wdata,
    output logic [$clog2(MAX_BLOCKS)-1:0]         mem_raddr,
    input  bdy_pkg::entry_t                       mem_rdata
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int OFF_W = MAX_ORDER + 1;
    localparam int OW    = bdy_pkg::ORD_W;
    localparam int SW    = bdy_pkg::SIZE_W;
    localparam int PW    = bdy_pkg::SIZE_W + 1;
    localparam int FW    = bdy_pkg::OFFS_W;

    bdy_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SW-1:0]    size_reg, size_next;
    logic [FW-1:0]    target_reg, target_next;
    logic [OW-1:0]    want_reg, want_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [OFF_W-1:0] acc_reg, acc_next;
    logic             hit_found_reg, hit_found_next;
    logic [CNT_W-1:0] hit_idx_reg, hit_idx_next;
    logic [OFF_W-1:0] hit_off_reg, hit_off_next;
    logic             lg_found_reg, lg_found_next;
    logic [CNT_W-1:0] lg_idx_reg, lg_idx_next;
    logic [OFF_W-1:0] lg_off_reg, lg_off_next;
    logic [OW-1:0]    lg_ord_reg, lg_ord_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [OW-1:0]    ord_reg, ord_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic [CNT_W-1:0] d_reg, d_next;
    bdy_pkg::status_t stat_reg, stat_next;
    logic [OFF_W-1:0] res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    bdy_pkg::status_t out_stat_reg, out_stat_next;
    logic [FW-1:0]    out_off_reg, out_off_next;

    // Helper terms used by the combinational blocks
    logic             usable;
    logic             bad_size;
    logic             want_lt;
    logic             last_scan;
    logic             full;
    logic             right_side;
    logic             buddy_ok;
    logic             out_free;
    logic [OFF_W-1:0] step;
    logic [OFF_W-1:0] off_sh;
    logic [CNT_W-1:0] j_inc, j_dec, r_inc, l_dec;
    logic [CNT_W-1:0] waddr_c, raddr_c;
    logic [PW-1:0]    pow_want, pow_total;

    assign usable    = (cfg.total_order >= cfg.min_order)
                       && (32'(cfg.total_order) <= MAX_ORDER);
    assign pow_total = PW'(1) << cfg.total_order;
    assign bad_size  = (cmd.request_size == '0)
                       || ((32'(cfg.total_order) < SW)
                           && ({1'b0, cmd.request_size} > pow_total));
    assign pow_want  = PW'(1) << want_reg;
    assign want_lt   = (32'(want_reg) < SW) && (pow_want < {1'b0, size_reg});
    assign j_inc     = j_reg + CNT_W'(1);
    assign j_dec     = j_reg - CNT_W'(1);
    assign r_inc     = hi_reg + CNT_W'(1);
    assign l_dec     = lo_reg - CNT_W'(1);
    assign last_scan = (j_inc == count_reg);
    assign step      = OFF_W'(1) << mem_rdata.order;
    assign full      = (32'(count_reg) + 32'(lg_ord_reg - want_reg)) > MAX_BLOCKS;
    assign off_sh    = off_reg >> ord_reg;
    assign right_side = ~off_sh[0];
    assign buddy_ok  = (mem_rdata.order == ord_reg) && mem_rdata.free;
    assign out_free  = !out_valid_reg || rsp.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bdy_pkg::S_INIT:
            begin
                state_next = bdy_pkg::S_IDLE;
            end
            bdy_pkg::S_IDLE:
            begin
                if (!cfg.init && cmd.valid)
                begin
                    if (cmd.command == bdy_pkg::CMD_FREE)
                    begin
                        state_next = usable ? bdy_pkg::S_FSCAN_RD : bdy_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = (usable && !bad_size) ? bdy_pkg::S_WANT
                                                           : bdy_pkg::S_DONE;
                    end
                end
            end
            bdy_pkg::S_WANT:
            begin
                if (!want_lt)
                begin
                    state_next = bdy_pkg::S_ASCAN_RD;
                end
            end
            bdy_pkg::S_ASCAN_RD:
            begin
                state_next = bdy_pkg::S_ASCAN_EV;
            end
            bdy_pkg::S_ASCAN_EV:
            begin
                state_next = last_scan ? bdy_pkg::S_ADECIDE : bdy_pkg::S_ASCAN_RD;
            end
            bdy_pkg::S_ADECIDE:
            begin
                if (hit_found_reg || !lg_found_reg || full)
                begin
                    state_next = bdy_pkg::S_DONE;
                end
                else if (lg_idx_reg + CNT_W'(1) == count_reg)
                begin
                    state_next = bdy_pkg::S_SPLIT_WR;
                end
                else
                begin
                    state_next = bdy_pkg::S_SHIFT_RD;
                end
            end
            bdy_pkg::S_SHIFT_RD:
            begin
                state_next = bdy_pkg::S_SHIFT_WR;
            end
            bdy_pkg::S_SHIFT_WR:
            begin
                state_next = (j_dec == lg_idx_reg) ? bdy_pkg::S_SPLIT_WR
                                                   : bdy_pkg::S_SHIFT_RD;
            end
            bdy_pkg::S_SPLIT_WR:
            begin
                if (j_reg == d_reg)
                begin
                    state_next = bdy_pkg::S_DONE;
                end
            end
            bdy_pkg::S_FSCAN_RD:
            begin
                if (j_reg == count_reg)
                begin
                    state_next = bdy_pkg::S_DONE;
                end
                else if (32'(acc_reg) == 32'(target_reg))
                begin
                    state_next = bdy_pkg::S_FHIT;
                end
                else
                begin
                    state_next = bdy_pkg::S_FSCAN_EV;
                end
            end
            bdy_pkg::S_FSCAN_EV:
            begin
                state_next = bdy_pkg::S_FSCAN_RD;
            end
            bdy_pkg::S_FHIT:
            begin
                state_next = bdy_pkg::S_MCHK;
            end
            bdy_pkg::S_MCHK:
            begin
                if ((ord_reg >= cfg.total_order)
                    || (right_side && (r_inc >= count_reg))
                    || (!right_side && (lo_reg == '0)))
                begin
                    state_next = bdy_pkg::S_MWR;
                end
                else
                begin
                    state_next = bdy_pkg::S_MEV;
                end
            end
            bdy_pkg::S_MEV:
            begin
                state_next = buddy_ok ? bdy_pkg::S_MCHK : bdy_pkg::S_MWR;
            end
            bdy_pkg::S_MWR:
            begin
                state_next = (r_inc >= count_reg) ? bdy_pkg::S_DONE : bdy_pkg::S_CRD;
            end
            bdy_pkg::S_CRD:
            begin
                state_next = bdy_pkg::S_CWR;
            end
            bdy_pkg::S_CWR:
            begin
                state_next = last_scan ? bdy_pkg::S_DONE : bdy_pkg::S_CRD;
            end
            bdy_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = bdy_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bdy_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, table port and handshake outputs
    always_comb
    begin
        count_next     = count_reg;
        size_next      = size_reg;
        target_next    = target_reg;
        want_next      = want_reg;
        j_next         = j_reg;
        acc_next       = acc_reg;
        hit_found_next = hit_found_reg;
        hit_idx_next   = hit_idx_reg;
        hit_off_next   = hit_off_reg;
        lg_found_next  = lg_found_reg;
        lg_idx_next    = lg_idx_reg;
        lg_off_next    = lg_off_reg;
        lg_ord_next    = lg_ord_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        ord_next       = ord_reg;
        off_next       = off_reg;
        d_next         = d_reg;
        stat_next      = stat_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_stat_next  = out_stat_reg;
        out_off_next   = out_off_reg;
        mem_we         = 1'b0;
        waddr_c        = '0;
        mem_wdata      = '0;
        raddr_c        = j_reg;
        cmd.ready      = 1'b0;

        case (state_reg)
            bdy_pkg::S_INIT:
            begin
                // Table starts as one free block of the whole heap
                mem_we          = 1'b1;
                mem_wdata.order = cfg.init ? cfg.init_order : cfg.total_order;
                mem_wdata.free  = 1'b1;
                count_next      = CNT_W'(1);
            end
            bdy_pkg::S_IDLE:
            begin
                cmd.ready = !cfg.init;
                if (cfg.init)
                begin
                    mem_we          = 1'b1;
                    mem_wdata.order = cfg.init_order;
                    mem_wdata.free  = 1'b1;
                    count_next      = CNT_W'(1);
                end
                else if (cmd.valid)
                begin
                    size_next      = cmd.request_size;
                    target_next    = cmd.free_offset;
                    want_next      = cfg.min_order;
                    j_next         = '0;
                    acc_next       = '0;
                    hit_found_next = 1'b0;
                    lg_found_next  = 1'b0;
                    res_next       = '0;
                    if (cmd.command == bdy_pkg::CMD_FREE)
                    begin
                        stat_next = usable ? bdy_pkg::STAT_OK : bdy_pkg::STAT_UNKNOWN;
                    end
                    else
                    begin
                        stat_next = (usable && !bad_size) ? bdy_pkg::STAT_OK
                                                          : bdy_pkg::STAT_BAD_SIZE;
                    end
                end
            end
            bdy_pkg::S_WANT:
            begin
                // Round the size up one order per cycle
                if (want_lt)
                begin
                    want_next = want_reg + OW'(1);
                end
            end
            bdy_pkg::S_ASCAN_EV:
            begin
                // Note the first exact fit and the first larger free block
                if (mem_rdata.free && (mem_rdata.order == want_reg) && !hit_found_reg)
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = j_reg;
                    hit_off_next   = acc_reg;
                end
                if (mem_rdata.free && (mem_rdata.order > want_reg) && !lg_found_reg)
                begin
                    lg_found_next = 1'b1;
                    lg_idx_next   = j_reg;
                    lg_off_next   = acc_reg;
                    lg_ord_next   = mem_rdata.order;
                end
                acc_next = acc_reg + step;
                j_next   = j_inc;
            end
            bdy_pkg::S_ADECIDE:
            begin
                if (hit_found_reg)
                begin
                    mem_we          = 1'b1;
                    waddr_c         = hit_idx_reg;
                    mem_wdata.order = want_reg;
                    mem_wdata.free  = 1'b0;
                    res_next        = hit_off_reg;
                end
                else if (!lg_found_reg)
                begin
                    stat_next = bdy_pkg::STAT_NO_SPACE;
                end
                else if (full)
                begin
                    stat_next = bdy_pkg::STAT_FULL;
                end
                else
                begin
                    d_next = CNT_W'(lg_ord_reg - want_reg);
                    j_next = (lg_idx_reg + CNT_W'(1) == count_reg) ? '0
                                                                   : count_reg - CNT_W'(1);
                end
            end
            bdy_pkg::S_SHIFT_WR:
            begin
                // Move the tail up to open room for the split halves
                mem_we    = 1'b1;
                waddr_c   = j_reg + d_reg;
                mem_wdata = mem_rdata;
                j_next    = (j_dec == lg_idx_reg) ? '0 : j_dec;
            end
            bdy_pkg::S_SPLIT_WR:
            begin
                mem_we  = 1'b1;
                waddr_c = lg_idx_reg + j_reg;
                if (j_reg == '0)
                begin
                    mem_wdata.order = want_reg;
                    mem_wdata.free  = 1'b0;
                end
                else
                begin
                    mem_wdata.order = OW'(32'(want_reg) + 32'(j_reg) - 32'd1);
                    mem_wdata.free  = 1'b1;
                end
                if (j_reg == d_reg)
                begin
                    count_next = count_reg + d_reg;
                    res_next   = lg_off_reg;
                end
                else
                begin
                    j_next = j_inc;
                end
            end
            bdy_pkg::S_FSCAN_RD:
            begin
                if (j_reg == count_reg)
                begin
                    stat_next = bdy_pkg::STAT_UNKNOWN;
                end
                else if (32'(acc_reg) == 32'(target_reg))
                begin
                    lo_next  = j_reg;
                    hi_next  = j_reg;
                    off_next = acc_reg;
                end
            end
            bdy_pkg::S_FSCAN_EV:
            begin
                acc_next = acc_reg + step;
                j_next   = j_inc;
            end
            bdy_pkg::S_FHIT:
            begin
                ord_next = mem_rdata.order;
            end
            bdy_pkg::S_MCHK:
            begin
                raddr_c = right_side ? r_inc : l_dec;
            end
            bdy_pkg::S_MEV:
            begin
                // Absorb the buddy into the merged span
                if (buddy_ok)
                begin
                    if (right_side)
                    begin
                        hi_next = r_inc;
                    end
                    else
                    begin
                        lo_next  = l_dec;
                        off_next = off_reg - (OFF_W'(1) << ord_reg);
                    end
                    ord_next = ord_reg + OW'(1);
                end
            end
            bdy_pkg::S_MWR:
            begin
                mem_we          = 1'b1;
                waddr_c         = lo_reg;
                mem_wdata.order = ord_reg;
                mem_wdata.free  = 1'b1;
                d_next          = hi_reg - lo_reg;
                j_next          = r_inc;
                if (r_inc >= count_reg)
                begin
                    count_next = count_reg - (hi_reg - lo_reg);
                end
            end
            bdy_pkg::S_CWR:
            begin
                // Close the gap left by the merged entries
                mem_we    = 1'b1;
                waddr_c   = j_reg - d_reg;
                mem_wdata = mem_rdata;
                if (last_scan)
                begin
                    count_next = count_reg - d_reg;
                end
                else
                begin
                    j_next = j_inc;
                end
            end
            bdy_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = stat_reg;
                    out_off_next   = FW'(res_reg);
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign mem_waddr        = waddr_c[IDX_W-1:0];
    assign mem_raddr        = raddr_c[IDX_W-1:0];
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_stat_reg;
    assign rsp.block_offset = out_off_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdy_pkg::S_INIT;
            count_reg     <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        size_reg      <= size_next;
        target_reg    <= target_next;
        want_reg      <= want_next;
        j_reg         <= j_next;
        acc_reg       <= acc_next;
        hit_found_reg <= hit_found_next;
        hit_idx_reg   <= hit_idx_next;
        hit_off_reg   <= hit_off_next;
        lg_found_reg  <= lg_found_next;
        lg_idx_reg    <= lg_idx_next;
        lg_off_reg    <= lg_off_next;
        lg_ord_reg    <= lg_ord_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        ord_reg       <= ord_next;
        off_reg       <= off_next;
        d_reg         <= d_next;
        stat_reg      <= stat_next;
        res_reg       <= res_next;
        out_stat_reg  <= out_stat_next;
        out_off_reg   <= out_off_next;
    end

endmodule

// ===== design/buddy_allocator.sv =====
// Buddy allocator over a heap of 2^total_order bytes, one command at a time. The block
// table sits in a memory with one write port and one registered read port, and one
// sequencer walks it with a shared offset adder. An allocate rounds the size up, scans
// the table entries, then moves entries and writes the new halves when a block is
// split. A free scans the entries up to the target, merges buddies, and moves entries
// to close the gap. The command channel is ready only between commands; the result
// waits in its own register. After reset, and after each configuration write made
// while the sequencer is idle, the table holds one free block of the whole heap; after
// reset the table is written before the first command is taken.
module buddy_allocator #(
    parameter int MAX_ORDER  = 16,
    parameter int MAX_BLOCKS = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bdy_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bdy_pkg::CFG_W-1:0]       cfg_data,
    bdy_cmd_if.sink                         cmd,
    bdy_rsp_if.source                       rsp
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);

    logic [bdy_pkg::CFG_W-1:0] min_order_reg;
    logic [bdy_pkg::CFG_W-1:0] total_order_reg;
    bdy_pkg::cfg_t             cfg;
    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    logic [IDX_W-1:0]          mem_raddr;
    bdy_pkg::entry_t           mem_wdata;
    bdy_pkg::entry_t           mem_rdata;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_order_reg   <= 5'd4;
            total_order_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            if (cfg_index == bdy_pkg::REG_MIN_ORDER)
            begin
                min_order_reg <= cfg_data;
            end
            else
            begin
                total_order_reg <= cfg_data;
            end
        end
    end

    // A write made while the sequencer is idle restarts the table with the heap order that will be in force
    always_comb
    begin
        cfg.min_order   = min_order_reg;
        cfg.total_order = total_order_reg;
        cfg.init        = cfg_we;
        cfg.init_order  = (cfg_index == bdy_pkg::REG_TOTAL_ORDER) ? cfg_data
                                                                  : total_order_reg;
    end

    bdy_ctrl #(
        .MAX_ORDER  (MAX_ORDER),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bdy_table #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int HEAP_MAX   = 16;
    localparam int TABLE_SIZE = 256;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [bdy_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bdy_pkg::CFG_W-1:0]     cfg_data;

    bdy_cmd_if cmd ();
    bdy_rsp_if rsp ();

    buddy_allocator #(.MAX_ORDER(HEAP_MAX), .MAX_BLOCKS(TABLE_SIZE)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .rsp       (rsp)
    );

    // Shadow copy of the allocator state.
    int     blk_order [TABLE_SIZE];
    bit     blk_free  [TABLE_SIZE];
    int     blk_count;
    int     shadow_min;
    int     shadow_total;

    // Expected responses, oldest first, and offsets currently handed out.
    bdy_pkg::status_t exp_status [$];
    logic [15:0]      exp_offset [$];
    logic [15:0]      live_blocks [$];

    int  fail_count;
    int  send_gap_pct;
    int  rsp_stall_pct;
    int  rsp_hold_cycles;
    bit  saw_table_full;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Restore the shadow table to one free block of the whole heap.
    function automatic void shadow_clear();
        blk_count    = 1;
        blk_order[0] = shadow_total & 31;
        blk_free[0]  = 1'b1;
    endfunction

    function automatic longint block_start(int idx);
        longint acc;
        acc = 0;
        for (int j = 0; j < idx && j < blk_count; j++)
            acc += longint'(1) << blk_order[j];
        return acc;
    endfunction

    function automatic bit heap_ok();
        return shadow_total >= shadow_min && shadow_total <= HEAP_MAX;
    endfunction

    // Allocation: exact fit first, otherwise split the first larger free block.
    function automatic bdy_pkg::status_t shadow_alloc(longint size, output longint where);
        int want;
        int i;
        where = 0;
        if (!heap_ok() || size == 0 || size > (longint'(1) << shadow_total))
            return bdy_pkg::STAT_BAD_SIZE;
        want = shadow_min;
        while ((longint'(1) << want) < size)
            want++;
        for (i = 0; i < blk_count; i++)
        begin
            if (blk_free[i] && blk_order[i] == want)
            begin
                blk_free[i] = 1'b0;
                where = block_start(i);
                return bdy_pkg::STAT_OK;
            end
        end
        for (i = 0; i < blk_count; i++)
            if (blk_free[i] && blk_order[i] > want)
                break;
        if (i >= blk_count)
            return bdy_pkg::STAT_NO_SPACE;
        if (blk_count + (blk_order[i] - want) > TABLE_SIZE)
            return bdy_pkg::STAT_FULL;
        while (blk_order[i] > want)
        begin
            for (int j = blk_count; j > i + 1; j--)
            begin
                blk_order[j] = blk_order[j-1];
                blk_free[j]  = blk_free[j-1];
            end
            blk_count++;
            blk_order[i] = blk_order[i] - 1;
            blk_order[i+1] = blk_order[i];
            blk_free[i+1]  = 1'b1;
        end
        blk_free[i] = 1'b0;
        where = block_start(i);
        return bdy_pkg::STAT_OK;
    endfunction

    // Release: find the block by offset, mark it free and merge with buddies.
    function automatic bdy_pkg::status_t shadow_release(longint target);
        int     i;
        int     o;
        int     left;
        longint pos;
        if (!heap_ok())
            return bdy_pkg::STAT_UNKNOWN;
        pos = 0;
        for (i = 0; i < blk_count; i++)
        begin
            if (pos == target)
                break;
            pos += longint'(1) << blk_order[i];
        end
        if (i >= blk_count)
            return bdy_pkg::STAT_UNKNOWN;
        blk_free[i] = 1'b1;
        forever
        begin
            o = blk_order[i];
            if (o >= shadow_total)
                break;
            pos = block_start(i);
            if (((pos >> o) & 1) == 0)
            begin
                if (i + 1 >= blk_count || blk_order[i+1] != o || !blk_free[i+1])
                    break;
                left = i;
            end
            else
            begin
                if (i == 0 || blk_order[i-1] != o || !blk_free[i-1])
                    break;
                left = i - 1;
            end
            blk_order[left] = o + 1;
            blk_free[left]  = 1'b1;
            for (int j = left + 1; j + 1 < blk_count; j++)
            begin
                blk_order[j] = blk_order[j+1];
                blk_free[j]  = blk_free[j+1];
            end
            blk_count--;
            i = left;
        end
        return bdy_pkg::STAT_OK;
    endfunction

    // Work out the response to one accepted command and queue it.
    function automatic void queue_response(bdy_pkg::cmd_t op, logic [16:0] size,
                                           logic [15:0] offs);
        bdy_pkg::status_t st;
        longint           where;
        where = 0;
        if (op == bdy_pkg::CMD_ALLOC)
            st = shadow_alloc(size, where);
        else
            st = shadow_release(offs);
        if (st != bdy_pkg::STAT_OK)
            where = 0;
        if (st == bdy_pkg::STAT_FULL)
            saw_table_full = 1'b1;
        if (op == bdy_pkg::CMD_ALLOC && st == bdy_pkg::STAT_OK)
            live_blocks.push_back(where[15:0]);
        exp_status.push_back(st);
        exp_offset.push_back(where[15:0]);
    endfunction

    // Send one command transaction; valid stays high on return unless a random gap drops it.
    task automatic send_cmd(bdy_pkg::cmd_t op, logic [16:0] size, logic [15:0] offs);
        bit ready_seen;
        cmd.valid        <= 1'b1;
        cmd.command      <= op;
        cmd.request_size <= size;
        cmd.free_offset  <= offs;
        do
        begin
            @(negedge clk);
            ready_seen = cmd.ready;
            @(posedge clk);
        end
        while (!ready_seen);
        queue_response(op, size, offs);
        if ($urandom_range(99) < send_gap_pct)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every response has been returned.
    task automatic drain();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (exp_status.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(bdy_pkg::reg_idx_t idx, int value);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[bdy_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == bdy_pkg::REG_MIN_ORDER)
            shadow_min = value & 31;
        else
            shadow_total = value & 31;
        shadow_clear();
        live_blocks.delete();
        @(posedge clk);
    endtask

    task automatic set_heap(int min_ord, int total_ord);
        write_reg(bdy_pkg::REG_MIN_ORDER, min_ord);
        write_reg(bdy_pkg::REG_TOTAL_ORDER, total_ord);
    endtask

    // Response ready: random stalls, or a long hold-off while the count runs.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else if (rsp_hold_cycles > 0)
        begin
            rsp.ready <= 1'b0;
            rsp_hold_cycles <= rsp_hold_cycles - 1;
        end
        else
        begin
            rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // Compare each response transaction with the oldest expectation.
    always @(negedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (exp_status.size() == 0)
            begin
                $error("unexpected response: status %0d offset %0h",
                       rsp.status, rsp.block_offset);
                fail_count++;
            end
            else
            begin
                if (rsp.status !== exp_status[0])
                begin
                    $error("status: expected %0d, got %0d", exp_status[0], rsp.status);
                    fail_count++;
                end
                if (rsp.block_offset !== exp_offset[0])
                begin
                    $error("block_offset: expected %0h, got %0h",
                           exp_offset[0], rsp.block_offset);
                    fail_count++;
                end
                void'(exp_status.pop_front());
                void'(exp_offset.pop_front());
            end
        end
    end

    // Edge cases of sizes and offsets on the reset configuration.
    task automatic test_directed();
        send_cmd(bdy_pkg::CMD_ALLOC, 17'd0, 16'd0);
        send_cmd(bdy_pkg::CMD_ALLOC, 17'h1FFFF, 16'hFFFF);
        send_cmd(bdy_pkg::CMD_ALLOC, 17'd65537, 16'd0);
        send_cmd(bdy_pkg::CMD_ALLOC, 17'd65536, 16'd0);
        send_cmd(bdy_pkg::CMD_ALLOC, 17'd1, 16'd0);
        send_cmd(bdy_pkg::CMD_FREE, 17'h1FFFF, 16'd0);
        send_cmd(bdy_pkg::CMD_FREE, 17'd0, 16'd0);
        send_cmd(bdy_pkg::CMD_FREE, 17'd0, 16'hFFFF);
        send_cmd(bdy_pkg::CMD_ALLOC, 17'd1, 16'd0);
        send_cmd(bdy_pkg::CMD_ALLOC, 17'd17, 16'd0);
        send_cmd(bdy_pkg::CMD_ALLOC, 17'd16, 16'd0);
        send_cmd(bdy_pkg::CMD_FREE, 17'd0, 16'd32);
        send_cmd(bdy_pkg::CMD_FREE, 17'd0, 16'd32);
        send_cmd(bdy_pkg::CMD_FREE, 17'd0, 16'd5);
        send_cmd(bdy_pkg::CMD_FREE, 17'd0, 16'd0);
        send_cmd(bdy_pkg::CMD_FREE, 17'd0, 16'd16);
    endtask

    // Extreme and unusable register settings.
    task automatic test_config_extremes();
        set_heap(16, 16);
        send_cmd(bdy_pkg::CMD_ALLOC, 17'd1, 16'd0);
        send_cmd(bdy_pkg::CMD_ALLOC, 17'd1, 16'd0);
        send_cmd(bdy_pkg::CMD_FREE, 17'd0, 16'd0);
        set_heap(0, 1);
        send_cmd(bdy_pkg::CMD_ALLOC, 17'd1, 16'd0);
        send_cmd(bdy_pkg::CMD_ALLOC, 17'd2, 16'd0);
        send_cmd(bdy_pkg::CMD_ALLOC, 17'd1, 16'd0);
        send_cmd(bdy_pkg::CMD_FREE, 17'd0, 16'd1);
        set_heap(5, 3);
        send_cmd(bdy_pkg::CMD_ALLOC, 17'd4, 16'd0);
        send_cmd(bdy_pkg::CMD_FREE, 17'd0, 16'd0);
        set_heap(31, 31);
        send_cmd(bdy_pkg::CMD_ALLOC, 17'd8, 16'd0);
        write_reg(bdy_pkg::REG_MIN_ORDER, 4);
        send_cmd(bdy_pkg::CMD_FREE, 17'd0, 16'd0);
    endtask

    // Smallest blocks on the largest heap until the table runs out of entries, then one free and one more allocation.
    task automatic test_table_full();
        int n;
        set_heap(0, 16);
        saw_table_full = 1'b0;
        n = 0;
        while (!saw_table_full && n < 400)
        begin
            send_cmd(bdy_pkg::CMD_ALLOC, 17'd1, 16'd0);
            n++;
        end
        send_cmd(bdy_pkg::CMD_FREE, 17'd0, live_blocks[$]);
        send_cmd(bdy_pkg::CMD_ALLOC, 17'd1, 16'd0);
    endtask

    // Mostly frees of live blocks and modest allocations, with some noise.
    task automatic random_item();
        int          pick;
        int          k;
        logic [16:0] size;
        pick = $urandom_range(99);
        if (pick < 40 && live_blocks.size() != 0)
        begin
            k = $urandom_range(live_blocks.size() - 1);
            send_cmd(bdy_pkg::CMD_FREE, 17'($urandom), live_blocks[k]);
            live_blocks.delete(k);
        end
        else if (pick < 48)
        begin
            send_cmd(bdy_pkg::CMD_FREE, 17'($urandom), 16'($urandom));
        end
        else if (pick < 52)
        begin
            send_cmd(bdy_pkg::CMD_ALLOC, 17'($urandom), 16'($urandom));
        end
        else
        begin
            size = 17'($urandom_range((1 << $urandom_range(0, shadow_total > 16 ? 16
                                       : shadow_total)), 1));
            send_cmd(bdy_pkg::CMD_ALLOC, size, 16'($urandom));
        end
    endtask

    task automatic test_random(int count, int gap_pct, int stall_pct);
        send_gap_pct  = gap_pct;
        rsp_stall_pct = stall_pct;
        set_heap($urandom_range(0, 6), $urandom_range(8, 16));
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                set_heap($urandom_range(0, 5), $urandom_range(6, 16));
            random_item();
        end
    endtask

    // Hold the response side off while commands keep coming, then let the
    // command side pause until everything has drained, then send twelve random items.
    task automatic test_backpressure();
        send_gap_pct  = 0;
        rsp_stall_pct = 0;
        set_heap(4, 12);
        rsp_hold_cycles = 3000;
        for (int n = 0; n < 12; n++)
            send_cmd(bdy_pkg::CMD_ALLOC, 17'd16, 16'd0);
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (exp_status.size() != 0)
            @(posedge clk);
        for (int n = 0; n < 12; n++)
            random_item();
    endtask

    // Stimulus sequence.
    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = bdy_pkg::REG_MIN_ORDER;
        cfg_data         = '0;
        cmd.valid        = 1'b0;
        cmd.command      = bdy_pkg::CMD_ALLOC;
        cmd.request_size = '0;
        cmd.free_offset  = '0;
        fail_count       = 0;
        send_gap_pct     = 0;
        rsp_stall_pct    = 0;
        rsp_hold_cycles  = 0;
        saw_table_full   = 1'b0;
        shadow_min       = 4;
        shadow_total     = 16;
        shadow_clear();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_extremes();
        test_table_full();
        test_backpressure();
        test_random(220, 0, 0);
        test_random(220, 67, 0);
        test_random(220, 0, 67);
        test_random(220, 67, 67);
        test_random(60, 24, 24);

        drain();
        repeat (1200) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Run time limit.
    initial
    begin
        #80_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
